// ===== hdl/irm_pkg.sv =====
package irm_pkg;

   localparam int ECHO_DEPTH_DEFAULT    = 64;
   localparam int CAPTURE_DEPTH_DEFAULT = 16;

   localparam int POSITION_WIDTH = 7;
   localparam int COUNT_WIDTH    = 5;

   typedef enum logic [1:0] {
      ACTION_RECEIVE = 2'd0,
      ACTION_ARM     = 2'd1,
      ACTION_LOAD    = 2'd2,
      ACTION_READ    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_SYNC     = 3'd1,
      MODE_OK       = 3'd2,
      MODE_ECHO_SEQ = 3'd3,
      MODE_ECHO_CMD = 3'd4,
      MODE_ECHO_SUM = 3'd5,
      MODE_CAPTURE  = 3'd6
   } mode_type;

   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;

   localparam logic [3:0] SYNC_LAST = 4'd11;
   localparam logic [7:0] OK_FIRST  = 8'h4F;
   localparam logic [7:0] OK_SECOND = 8'h4B;

   typedef struct packed {
      mode_type                    wait_mode;
      logic [POSITION_WIDTH-1:0]   match_position;
      logic [COUNT_WIDTH-1:0]      capture_count;
      logic                        completed;
      logic [7:0]                  read_data;
   } result_type;

   function automatic logic [7:0] sync_char(input logic [3:0] pos);
      logic [7:0] ch;
      unique case (pos)
         4'd0:    ch = 8'h53;
         4'd1:    ch = 8'h79;
         4'd2:    ch = 8'h6E;
         4'd3:    ch = 8'h63;
         4'd4:    ch = 8'h68;
         4'd5:    ch = 8'h72;
         4'd6:    ch = 8'h6F;
         4'd7:    ch = 8'h6E;
         4'd8:    ch = 8'h69;
         4'd9:    ch = 8'h7A;
         4'd10:   ch = 8'h65;
         4'd11:   ch = 8'h64;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic is_echo(input mode_type m);
      return (m == MODE_ECHO_SEQ) || (m == MODE_ECHO_CMD) || (m == MODE_ECHO_SUM);
   endfunction

endpackage

// ===== hdl/isp_response_matcher.sv =====
// Channel | Direction | Fields
// req     | in        | action, data_byte, new_mode, load_first, read_index
// rsp     | out       | wait_mode, match_position, capture_count, completed, read_data
//
// One transaction per cycle sustained while rsp_ready is high; each result passes the
// pending stage and then the output stage (state update and memory reads in the accept
// cycle, result assembled from registered read data as it moves to the output stage).
// The echo memory read data always holds the entry at the current echo position,
// kept valid by reading the next position every cycle with write forwarding.
// Reset is synchronous and clears mode (to sync), positions, lengths, counts and the stage valid flags only.
// A waiting result does not block one further transaction; req_ready falls only when
// both pipeline stages are full and rsp_ready is low.
module isp_response_matcher #(
   parameter int ECHO_DEPTH    = irm_pkg::ECHO_DEPTH_DEFAULT,
   parameter int CAPTURE_DEPTH = irm_pkg::CAPTURE_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_action,
   input  logic [7:0]                            req_data_byte,
   input  logic [2:0]                            req_new_mode,
   input  logic                                  req_load_first,
   input  logic [3:0]                            req_read_index,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [2:0]                            rsp_wait_mode,
   output logic [irm_pkg::POSITION_WIDTH-1:0]    rsp_match_position,
   output logic [irm_pkg::COUNT_WIDTH-1:0]       rsp_capture_count,
   output logic                                  rsp_completed,
   output logic [7:0]                            rsp_read_data
);
   import irm_pkg::*;

   localparam int EAW = $clog2(ECHO_DEPTH);
   localparam int EPW = $clog2(ECHO_DEPTH + 1);
   localparam int CAW = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1;
   localparam int CPW = $clog2(CAPTURE_DEPTH + 1);
   localparam int CMW = CPW + 4;

   logic [7:0] echo_mem [ECHO_DEPTH];
   logic [7:0] cap_mem  [CAPTURE_DEPTH];

   mode_type          mode_ff, mode_in;
   logic [3:0]        sync_pos_ff, sync_pos_in;
   logic              ok_pos_ff, ok_pos_in;
   logic [EAW-1:0]    echo_pos_ff, echo_pos_in;
   logic [EPW-1:0]    echo_len_ff, echo_len_in;
   logic [CPW-1:0]    cap_cnt_ff, cap_cnt_in;
   logic [7:0]        echo_rd_ff;
   logic [7:0]        cap_rd_ff;

   logic              p_valid_ff, p_valid_in;
   result_type        p_res_ff, p_res_in;
   logic              p_read_ok_ff, p_read_ok_in;
   logic              out_valid_ff, out_valid_in;
   result_type        out_res_ff, out_res_in;

   logic              accept, out_take, p_move;
   action_type        action;
   logic              is_text;
   logic              sync_hit, ok_hit, echo_hit;
   logic [EPW-1:0]    echo_next;
   logic              done;
   logic              echo_we;
   logic [EAW-1:0]    echo_wa;
   logic              cap_we;
   logic [CAW-1:0]    cap_wa, cap_ra;

   assign out_take  = !out_valid_ff || rsp_ready;
   assign p_move    = p_valid_ff && out_take;
   assign req_ready = !p_valid_ff || out_take;
   assign accept    = req_valid && req_ready;
   assign action    = action_type'(req_action);
   assign is_text   = (req_data_byte != CHAR_LF) && (req_data_byte != CHAR_CR);

   assign sync_hit  = (sync_char(sync_pos_ff) == req_data_byte);
   assign ok_hit    = ((ok_pos_ff ? OK_SECOND : OK_FIRST) == req_data_byte);
   assign echo_hit  = (EPW'(echo_pos_ff) < echo_len_ff) && (echo_rd_ff == req_data_byte);
   assign echo_next = echo_hit ? (EPW'(echo_pos_ff) + EPW'(1)) : '0;
   assign cap_ra    = CAW'(req_read_index);

   // next mode
   always_comb begin
      mode_in = mode_ff;
      if (accept) begin
         unique case (action)
            ACTION_RECEIVE: begin
               if (is_text) begin
                  unique case (mode_ff)
                     MODE_SYNC: begin
                        if (sync_hit && sync_pos_ff == SYNC_LAST) mode_in = MODE_IDLE;
                     end
                     MODE_OK: begin
                        if (ok_hit && ok_pos_ff) mode_in = MODE_IDLE;
                     end
                     MODE_ECHO_SEQ: begin
                        if (echo_next == echo_len_ff) mode_in = MODE_IDLE;
                     end
                     MODE_ECHO_CMD: begin
                        if (echo_next == echo_len_ff) mode_in = MODE_CAPTURE;
                     end
                     MODE_ECHO_SUM: begin
                        if (echo_next == echo_len_ff) mode_in = MODE_OK;
                     end
                     default: mode_in = mode_ff;
                  endcase
               end
            end
            ACTION_ARM: begin
               if (req_new_mode <= 3'(MODE_CAPTURE)) mode_in = mode_type'(req_new_mode);
            end
            default: mode_in = mode_ff;
         endcase
      end
   end

   // datapath and memory controls
   always_comb begin
      sync_pos_in  = sync_pos_ff;
      ok_pos_in    = ok_pos_ff;
      echo_pos_in  = echo_pos_ff;
      echo_len_in  = echo_len_ff;
      cap_cnt_in   = cap_cnt_ff;
      done         = 1'b0;
      echo_we      = 1'b0;
      echo_wa      = '0;
      cap_we       = 1'b0;
      cap_wa       = cap_cnt_ff[CAW-1:0];
      p_read_ok_in = 1'b0;
      if (accept) begin
         unique case (action)
            ACTION_RECEIVE: begin
               if (is_text) begin
                  case (mode_ff)
                     MODE_SYNC: begin
                        if (sync_hit && sync_pos_ff == SYNC_LAST) begin
                           sync_pos_in = '0;
                           done        = 1'b1;
                        end else if (sync_hit) begin
                           sync_pos_in = sync_pos_ff + 4'd1;
                        end else begin
                           sync_pos_in = '0;
                        end
                     end
                     MODE_OK: begin
                        done      = ok_hit && ok_pos_ff;
                        ok_pos_in = ok_hit && !ok_pos_ff;
                     end
                     MODE_ECHO_SEQ, MODE_ECHO_CMD, MODE_ECHO_SUM: begin
                        if (echo_next == echo_len_ff) begin
                           echo_pos_in = '0;
                           done        = 1'b1;
                        end else begin
                           echo_pos_in = echo_next[EAW-1:0];
                        end
                     end
                     MODE_CAPTURE: begin
                        if (cap_cnt_ff < CPW'(CAPTURE_DEPTH)) begin
                           cap_we     = 1'b1;
                           cap_cnt_in = cap_cnt_ff + CPW'(1);
                        end
                     end
                     default: done = 1'b0;
                  endcase
               end
            end
            ACTION_ARM: begin
               if (req_new_mode <= 3'(MODE_CAPTURE)) begin
                  if (is_echo(mode_type'(req_new_mode))) echo_pos_in = '0;
                  if (req_new_mode == 3'(MODE_ECHO_CMD)) cap_cnt_in = '0;
               end
            end
            ACTION_LOAD: begin
               if (req_load_first) begin
                  echo_we     = 1'b1;
                  echo_wa     = '0;
                  echo_len_in = EPW'(1);
                  echo_pos_in = '0;
               end else if (echo_len_ff < EPW'(ECHO_DEPTH)) begin
                  echo_we     = 1'b1;
                  echo_wa     = echo_len_ff[EAW-1:0];
                  echo_len_in = echo_len_ff + EPW'(1);
               end
            end
            ACTION_READ: begin
               p_read_ok_in = CMW'(req_read_index) < CMW'(cap_cnt_ff);
            end
            default: done = 1'b0;
         endcase
      end
   end

   always_comb begin
      p_res_in                = '0;
      p_res_in.wait_mode      = mode_in;
      p_res_in.capture_count  = COUNT_WIDTH'(cap_cnt_in);
      p_res_in.completed      = done;
      if (mode_in == MODE_SYNC) begin
         p_res_in.match_position = POSITION_WIDTH'(sync_pos_in);
      end else if (mode_in == MODE_OK) begin
         p_res_in.match_position = POSITION_WIDTH'(ok_pos_in);
      end else if (is_echo(mode_in)) begin
         p_res_in.match_position = POSITION_WIDTH'(echo_pos_in);
      end

      p_valid_in = accept ? 1'b1 : (p_move ? 1'b0 : p_valid_ff);

      out_valid_in = p_move ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
      out_res_in   = out_res_ff;
      if (p_move) begin
         out_res_in           = p_res_ff;
         out_res_in.read_data = p_read_ok_ff ? cap_rd_ff : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_SYNC;
         sync_pos_ff  <= '0;
         ok_pos_ff    <= 1'b0;
         echo_pos_ff  <= '0;
         echo_len_ff  <= '0;
         cap_cnt_ff   <= '0;
         p_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         sync_pos_ff  <= sync_pos_in;
         ok_pos_ff    <= ok_pos_in;
         echo_pos_ff  <= echo_pos_in;
         echo_len_ff  <= echo_len_in;
         cap_cnt_ff   <= cap_cnt_in;
         p_valid_ff   <= p_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p_res_ff     <= p_res_in;
         p_read_ok_ff <= p_read_ok_in;
      end
      out_res_ff <= out_res_in;
   end

   // hold the entry at the next echo position, forwarding a same-cycle write
   always_ff @(posedge clock) begin
      if (echo_we) begin
         echo_mem[echo_wa] <= req_data_byte;
      end
      if (echo_we && echo_wa == echo_pos_in) begin
         echo_rd_ff <= req_data_byte;
      end else begin
         echo_rd_ff <= echo_mem[echo_pos_in];
      end
   end

   always_ff @(posedge clock) begin
      if (cap_we) begin
         cap_mem[cap_wa] <= req_data_byte;
      end
      if (accept) begin
         cap_rd_ff <= cap_mem[cap_ra];
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_wait_mode      = out_res_ff.wait_mode;
   assign rsp_match_position = out_res_ff.match_position;
   assign rsp_capture_count  = out_res_ff.capture_count;
   assign rsp_completed      = out_res_ff.completed;
   assign rsp_read_data      = out_res_ff.read_data;

   a_cap_bound: assert property (@(posedge clock) disable iff (reset)
      cap_cnt_ff <= CPW'(CAPTURE_DEPTH))
      else $error("capture count exceeds store depth");

   a_echo_pos: assert property (@(posedge clock) disable iff (reset)
      (echo_len_ff == '0 && echo_pos_ff == '0) || (EPW'(echo_pos_ff) < echo_len_ff))
      else $error("echo position outside expected string");

   a_done_mode: assert property (@(posedge clock) disable iff (reset)
      (accept && done) |=> (mode_ff == MODE_IDLE || mode_ff == MODE_CAPTURE
                            || mode_ff == MODE_OK))
      else $error("completed match left mode in a matching state");

   a_pend_hold: assert property (@(posedge clock) disable iff (reset)
      (p_valid_ff && !p_move) |=> (p_valid_ff && $stable(p_res_ff)))
      else $error("pending result lost while stalled");

   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && action != ACTION_READ) |=> !p_read_ok_ff)
      else $error("read data enabled for a non-read transaction");

endmodule
